// File: design/imu_trc_pkg.sv
// Shared constants, types and arctangent table for the IMU tilt and rate converter.
package imu_trc_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int ATAN_LEN        = 24;
  localparam int NSTG            = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int AXIS_W     = 17;
  localparam int SQ_W       = 34;
  localparam int SQ_PAIRS   = SQ_W / 2;
  localparam int FRAC_PAIRS = 12;
  localparam int ROOT_W     = SQ_PAIRS + FRAC_PAIRS;
  localparam int REM_W      = ROOT_W + 3;
  localparam int CW         = 32;
  localparam int ANGLE_SH   = 30 - ANGLE_FRAC_BITS;

  localparam int PIPE_LAST  = ROOT_W + NSTG + 3;

  localparam int RATE_SH    = 32;
  localparam int RATE_Q_W   = 17;
  localparam logic [25:0] RATE_MUL  = 26'd32786010;
  localparam logic [24:0] RATE_BIAS = 25'd65;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACC_X = 3'd0,
    CFG_ACC_Y = 3'd1,
    CFG_ACC_Z = 3'd2,
    CFG_GYR_X = 3'd3,
    CFG_GYR_Y = 3'd4
  } cfg_idx_e;

  typedef logic signed [15:0] raw_t;
  typedef logic signed [15:0] tilt_t;
  typedef logic signed [18:0] rate_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  function automatic logic [CW-1:0] atan_q30(input int idx);
    logic [CW-1:0] v;
    case (idx)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/imu_trc_smp_if.sv
// Input channel carrying one raw IMU sample set.
interface imu_trc_smp_if;
  import imu_trc_pkg::*;
  logic valid;
  logic ready;
  raw_t acc_x;
  raw_t acc_y;
  raw_t acc_z;
  raw_t gyro_x;
  raw_t gyro_y;

  modport source (output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, output ready);
endinterface

// File: design/imu_trc_res_if.sv
// Output channel carrying tilt angles and scaled rates.
interface imu_trc_res_if;
  import imu_trc_pkg::*;
  logic  valid;
  logic  ready;
  tilt_t x_tilt;
  tilt_t y_tilt;
  rate_t y_rate;
  rate_t x_rate;

  modport source (output valid, x_tilt, y_tilt, y_rate, x_rate, input ready);
  modport sink   (input valid, x_tilt, y_tilt, y_rate, x_rate, output ready);
endinterface

// File: design/imu_tilt_and_rate_convert_unit.sv
// Top level of the IMU tilt and rate converter.
//
// A raw sample set (three accelerometer axes, two gyro axes) enters on smp_i
// and one result (x_tilt, y_tilt in Q2.14 radians, y_rate, x_rate in Q.9)
// leaves on res_o. Both are valid/ready channels; a transaction completes at
// a clock edge where valid and ready are both high.
// From accepting a sample set to showing its result it passes one correction
// stage, two stages for the squares and their sum, 29 square root stages (one
// result bit each), 16 CORDIC stages and one rounding stage.
// The pipeline accepts one sample set per cycle while res_o is not stalled.
// When res_o is stalled with a result waiting, the whole pipeline holds and
// smp_i.ready drops; nothing is lost or repeated. While no result waits at
// res_o, the pipeline advances every cycle, empty slots included.
// Calibration offsets are written through cfg_we_i, cfg_idx_i and cfg_data_i
// while the block is idle; the user must keep to this, the block does not enforce
// it. Reset clears all offsets to zero and empties the pipeline.
module imu_tilt_and_rate_convert_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [imu_trc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [imu_trc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  imu_trc_smp_if.sink                         smp_i,
  imu_trc_res_if.source                       res_o
);
  import imu_trc_pkg::*;

  logic signed [13:0] acc_x_off_q, acc_y_off_q, acc_z_off_q;
  logic signed [15:0] gyr_x_off_q, gyr_y_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_off_q <= '0;
      acc_y_off_q <= '0;
      acc_z_off_q <= '0;
      gyr_x_off_q <= '0;
      gyr_y_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACC_X: acc_x_off_q <= cfg_data_i[13:0];
        CFG_ACC_Y: acc_y_off_q <= cfg_data_i[13:0];
        CFG_ACC_Z: acc_z_off_q <= cfg_data_i[13:0];
        CFG_GYR_X: gyr_x_off_q <= cfg_data_i;
        CFG_GYR_Y: gyr_y_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [PIPE_LAST:0] v_q;
  logic               en;

  assign en          = !v_q[PIPE_LAST] || res_o.ready;
  assign smp_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAST-1:0], smp_i.valid};
    end
  end

  axis_t       ax_q, ay_q, az_q;
  logic [15:0] gx_mag_q, gy_mag_q;
  logic        gx_neg_q, gy_neg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q     <= AXIS_W'(smp_i.acc_x) + AXIS_W'(acc_x_off_q);
      ay_q     <= AXIS_W'(smp_i.acc_y) + AXIS_W'(acc_y_off_q);
      az_q     <= AXIS_W'(smp_i.acc_z) + AXIS_W'(acc_z_off_q);
      gx_neg_q <= smp_i.gyro_x[15];
      gy_neg_q <= smp_i.gyro_y[15];
      gx_mag_q <= smp_i.gyro_x[15] ? 16'(-smp_i.gyro_x) : smp_i.gyro_x;
      gy_mag_q <= smp_i.gyro_y[15] ? 16'(-smp_i.gyro_y) : smp_i.gyro_y;
    end
  end

  logic [24:0] gx_num, gy_num;
  logic [50:0] gx_prod, gy_prod;

  assign gx_num  = {gx_mag_q, 9'b0} + RATE_BIAS;
  assign gy_num  = {gy_mag_q, 9'b0} + RATE_BIAS;
  assign gx_prod = 51'(gx_num) * 51'(RATE_MUL);
  assign gy_prod = 51'(gy_num) * 51'(RATE_MUL);

  logic [RATE_Q_W-1:0] gx_q_q [1:PIPE_LAST-1];
  logic [RATE_Q_W-1:0] gy_q_q [1:PIPE_LAST-1];
  logic                gxs_q  [1:PIPE_LAST-1];
  logic                gys_q  [1:PIPE_LAST-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q_q[1] <= gx_prod[RATE_SH+RATE_Q_W-1:RATE_SH];
      gy_q_q[1] <= gy_prod[RATE_SH+RATE_Q_W-1:RATE_SH];
      gxs_q[1]  <= gx_neg_q;
      gys_q[1]  <= gy_neg_q;
      for (int k = 2; k < PIPE_LAST; k++) begin
        gx_q_q[k] <= gx_q_q[k-1];
        gy_q_q[k] <= gy_q_q[k-1];
        gxs_q[k]  <= gxs_q[k-1];
        gys_q[k]  <= gys_q[k-1];
      end
    end
  end

  rate_t y_rate_q, x_rate_q, gx_off, gy_off, gx_mag, gy_mag;

  assign gx_off = 19'(gyr_x_off_q);
  assign gy_off = 19'(gyr_y_off_q);
  assign gx_mag = 19'(gx_q_q[PIPE_LAST-1]);
  assign gy_mag = 19'(gy_q_q[PIPE_LAST-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_rate_q <= gxs_q[PIPE_LAST-1] ? gx_off - gx_mag : gx_off + gx_mag;
      x_rate_q <= gys_q[PIPE_LAST-1] ? gy_off - gy_mag : gy_off + gy_mag;
    end
  end

  tilt_t x_tilt, y_tilt;

  imu_trc_tilt u_x_tilt (
    .clk_i    (clk_i),
    .en_i     (en),
    .negate_i (1'b0),
    .num_i    (ay_q),
    .a_i      (ax_q),
    .b_i      (az_q),
    .tilt_o   (x_tilt)
  );

  imu_trc_tilt u_y_tilt (
    .clk_i    (clk_i),
    .en_i     (en),
    .negate_i (1'b1),
    .num_i    (ax_q),
    .a_i      (ay_q),
    .b_i      (az_q),
    .tilt_o   (y_tilt)
  );

  assign res_o.valid  = v_q[PIPE_LAST];
  assign res_o.x_tilt = x_tilt;
  assign res_o.y_tilt = y_tilt;
  assign res_o.y_rate = y_rate_q;
  assign res_o.x_rate = x_rate_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_i.valid && smp_i.ready |=> v_q[0])
    else $error("Accepted transaction did not enter the pipeline.");

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> $stable(v_q))
    else $error("Pipeline valid bits moved during an output stall.");

  a_stall_holds_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> $stable(y_rate_q) && $stable(x_tilt))
    else $error("Output data changed during an output stall.");

  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i > CFG_GYR_Y) |=>
      $stable(gyr_y_off_q) && $stable(gyr_x_off_q) && $stable(acc_x_off_q))
    else $error("Write to an unused register index changed an offset.");

endmodule

// File: design/imu_trc_tilt.sv
// Pipelined tilt angle: squares, bitwise square root, vectoring CORDIC, rounding.
module imu_trc_tilt (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  negate_i,
  input  imu_trc_pkg::axis_t    num_i,
  input  imu_trc_pkg::axis_t    a_i,
  input  imu_trc_pkg::axis_t    b_i,
  output imu_trc_pkg::tilt_t    tilt_o
);
  import imu_trc_pkg::*;

  logic signed [2*AXIS_W-1:0] sqa, sqb;
  logic [31:0]     a2_q, b2_q;
  axis_t           num1_q, num2_q;
  logic            zero1_q, zero2_q;
  logic [SQ_W-1:0] sq_q;

  assign sqa = a_i * a_i;
  assign sqb = b_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q    <= sqa[31:0];
      b2_q    <= sqb[31:0];
      num1_q  <= num_i;
      zero1_q <= (a_i == '0) && (b_i == '0) && (num_i == '0);
      sq_q    <= {1'b0, {1'b0, a2_q} + {1'b0, b2_q}};
      num2_q  <= num1_q;
      zero2_q <= zero1_q;
    end
  end

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   sqv_q  [ROOT_W];
  axis_t             snum_q [ROOT_W];
  logic              sz_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_p, rem_s, trial, rem_n;
    logic [ROOT_W-1:0] root_p, root_n;
    logic [SQ_W-1:0]   sq_p;
    axis_t             num_p;
    logic              z_p;
    logic [1:0]        pair;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign sq_p   = sq_q;
      assign num_p  = num2_q;
      assign z_p    = zero2_q;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign sq_p   = sqv_q[k-1];
      assign num_p  = snum_q[k-1];
      assign z_p    = sz_q[k-1];
    end

    if (k < SQ_PAIRS) begin : g_pair
      assign pair = sq_p[SQ_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem_s = {rem_p[REM_W-3:0], pair};
      trial = REM_W'({root_p, 2'b01});
      if (rem_s >= trial) begin
        rem_n  = rem_s - trial;
        root_n = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n  = rem_s;
        root_n = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        root_q[k] <= root_n;
        sqv_q[k]  <= sq_p;
        snum_q[k] <= num_p;
        sz_q[k]   <= z_p;
      end
    end
  end

  logic signed [CW-1:0] x_q  [NSTG];
  logic signed [CW-1:0] y_q  [NSTG];
  logic signed [CW-1:0] z_q  [NSTG];
  logic                 cz_q [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    logic signed [CW-1:0] x_p, y_p, z_p, dx, dy;
    logic                 zf_p;

    if (i == 0) begin : g_first
      assign x_p  = CW'(root_q[ROOT_W-1]);
      assign y_p  = {{(CW-AXIS_W-12){snum_q[ROOT_W-1][AXIS_W-1]}}, snum_q[ROOT_W-1], 12'b0};
      assign z_p  = '0;
      assign zf_p = sz_q[ROOT_W-1];
    end else begin : g_next
      assign x_p  = x_q[i-1];
      assign y_p  = y_q[i-1];
      assign z_p  = z_q[i-1];
      assign zf_p = cz_q[i-1];
    end

    assign dx = y_p >>> i;
    assign dy = x_p >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_p[CW-1]) begin
          x_q[i] <= x_p + dx;
          y_q[i] <= y_p - dy;
          z_q[i] <= z_p + signed'(atan_q30(i));
        end else begin
          x_q[i] <= x_p - dx;
          y_q[i] <= y_p + dy;
          z_q[i] <= z_p - signed'(atan_q30(i));
        end
        cz_q[i] <= zf_p;
      end
    end
  end

  logic [CW-1:0]        zmag, rnd;
  logic signed [CW+1:0] ang;
  logic                 neg;
  tilt_t                tilt_d, tilt_q;

  always_comb begin
    zmag = z_q[NSTG-1][CW-1] ? CW'(-z_q[NSTG-1]) : CW'(z_q[NSTG-1]);
    rnd  = (zmag + CW'(1 << (ANGLE_SH - 1))) >> ANGLE_SH;
    neg  = z_q[NSTG-1][CW-1] ^ negate_i;
    ang  = neg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
    if (cz_q[NSTG-1]) begin
      tilt_d = '0;
    end else if (ang > 34'sd32767) begin
      tilt_d = 16'sh7fff;
    end else if (ang < -34'sd32768) begin
      tilt_d = -16'sh8000;
    end else begin
      tilt_d = ang[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tilt_q <= tilt_d;
    end
  end

  assign tilt_o = tilt_q;

endmodule

// File: sim/imu_tilt_and_rate_convert_unit_tb.sv
// Self-checking testbench for the IMU tilt and rate converter: directed and random sample sets.
module imu_tilt_and_rate_convert_unit_tb;
  import imu_trc_pkg::*;

  typedef struct {
    raw_t ax, ay, az, gx, gy;
  } sample_t;

  typedef struct {
    tilt_t x_tilt, y_tilt;
    rate_t y_rate, x_rate;
  } tilt_rate_t;

  localparam cfg_idx_e CFG_LIST [5] = '{CFG_ACC_X, CFG_ACC_Y, CFG_ACC_Z, CFG_GYR_X, CFG_GYR_Y};
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;
  localparam int PIPE_DRAIN = 60;

  class tilt_rate_scoreboard;
    logic signed [13:0] acc_off [3];
    logic signed [15:0] gyr_off [2];
    tilt_rate_t expected_q [$];
    int unsigned errors, checked, noted;
    longint arctan_tab [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

    function void clear();
      foreach (acc_off[i]) acc_off[i] = '0;
      foreach (gyr_off[i]) gyr_off[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ACC_X: acc_off[0] = data[13:0];
        CFG_ACC_Y: acc_off[1] = data[13:0];
        CFG_ACC_Z: acc_off[2] = data[13:0];
        CFG_GYR_X: gyr_off[0] = data;
        CFG_GYR_Y: gyr_off[1] = data;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function longint tilt_of(longint num, longint a, longint b);
      longint x, y, z, dx, dy, mag, r;
      int sh;
      x = longint'(int_sqrt(longint'(a * a + b * b) << 24));
      y = num * 4096;
      z = 0;
      if (x == 0 && y == 0) return 0;
      for (int i = 0; i < NSTG; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += arctan_tab[i];
        end else begin
          x -= dx; y += dy; z -= arctan_tab[i];
        end
      end
      sh = 30 - ANGLE_FRAC_BITS;
      mag = z < 0 ? -z : z;
      r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return z < 0 ? -r : r;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint rate_of(longint g);
      longint mag, q;
      mag = g < 0 ? -g : g;
      q = (mag * 512 + 65) / 131;
      return g < 0 ? -q : q;
    endfunction

    function void note_sample(sample_t s);
      longint ax, ay, az;
      tilt_rate_t e;
      ax = longint'(s.ax) + longint'(acc_off[0]);
      ay = longint'(s.ay) + longint'(acc_off[1]);
      az = longint'(s.az) + longint'(acc_off[2]);
      e.x_tilt = tilt_t'(clip16(tilt_of(ay, ax, az)));
      e.y_tilt = tilt_t'(clip16(-tilt_of(ax, ay, az)));
      e.y_rate = rate_t'(rate_of(longint'(s.gx)) + longint'(gyr_off[0]));
      e.x_rate = rate_t'(rate_of(longint'(s.gy)) + longint'(gyr_off[1]));
      expected_q.push_back(e);
      noted++;
    endfunction

    function void check_result(tilt_rate_t a);
      tilt_rate_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x_tilt=%0d y_tilt=%0d y_rate=%0d x_rate=%0d",
                 $time, a.x_tilt, a.y_tilt, a.y_rate, a.x_rate);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.x_tilt !== e.x_tilt) begin
        $display("%0t: x_tilt expected %0d actual %0d", $time, e.x_tilt, a.x_tilt);
        errors++;
      end
      if (a.y_tilt !== e.y_tilt) begin
        $display("%0t: y_tilt expected %0d actual %0d", $time, e.y_tilt, a.y_tilt);
        errors++;
      end
      if (a.y_rate !== e.y_rate) begin
        $display("%0t: y_rate expected %0d actual %0d", $time, e.y_rate, a.y_rate);
        errors++;
      end
      if (a.x_rate !== e.x_rate) begin
        $display("%0t: x_rate expected %0d actual %0d", $time, e.x_rate, a.x_rate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit idle_en;
  int unsigned cfg_writes;

  imu_trc_smp_if smp ();
  imu_trc_res_if res ();

  tilt_rate_scoreboard sb;

  imu_tilt_and_rate_convert_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .smp_i     (smp),
    .res_o     (res)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && smp.valid && smp.ready) begin
      sb.note_sample('{smp.acc_x, smp.acc_y, smp.acc_z, smp.gyro_x, smp.gyro_y});
    end
    if (rst_ni && res.valid && res.ready) begin
      sb.check_result('{res.x_tilt, res.y_tilt, res.y_rate, res.x_rate});
    end
  end

  initial begin
    res.ready = 1'b0;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(sample_t s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.acc_x  <= s.ax;
    smp.acc_y  <= s.ay;
    smp.acc_z  <= s.az;
    smp.gyro_x <= s.gx;
    smp.gyro_y <= s.gy;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  // Waits for the pipeline to drain, then loads all five offsets and writes random data to the unused indexes.
  task automatic load_offsets(int acc_v [3], int gyr_v [2]);
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    for (int i = 0; i < 3; i++) write_reg(CFG_LIST[i], CFG_DATA_W'(acc_v[i]));
    for (int i = 0; i < 2; i++) write_reg(CFG_LIST[3 + i], CFG_DATA_W'(gyr_v[i]));
    for (int k = int'(CFG_UNUSED_FIRST); k <= int'(CFG_UNUSED_LAST); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic raw_t rand_axis();
    case ($urandom_range(0, 5))
      0: return raw_t'($urandom);
      1: return raw_t'($urandom);
      2: return raw_t'($urandom_range(0, 600) - 300);
      3: return raw_t'($urandom_range(0, 8192) - 4096);
      4: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_axis();
    s.ay = rand_axis();
    s.az = rand_axis();
    s.gx = raw_t'($urandom);
    s.gy = raw_t'($urandom);
    // Cancel the offsets now and then so the corrected axes reach zero.
    if ($urandom_range(0, 9) == 0) s.ax = -raw_t'(sb.acc_off[0]);
    if ($urandom_range(0, 9) == 0) s.ay = -raw_t'(sb.acc_off[1]);
    if ($urandom_range(0, 9) == 0) s.az = -raw_t'(sb.acc_off[2]);
    return s;
  endfunction

  initial begin
    int acc_v [3];
    int gyr_v [2];
    sample_t directed [$];
    sb = new();
    sb.clear();
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    smp.valid  = 1'b0;
    smp.acc_x  = '0;
    smp.acc_y  = '0;
    smp.acc_z  = '0;
    smp.gyro_x = '0;
    smp.gyro_y = '0;
    idle_en    = 1'b1;
    cfg_writes = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd1000, 16'sd1, -16'sd1},
      '{16'sd0, 16'sd1000, 16'sd0, 16'sh7fff, 16'sh8000},
      '{16'sd1000, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff},
      '{16'sd0, -16'sd1000, 16'sd0, 16'sd65, -16'sd66},
      '{-16'sd1000, 16'sd0, 16'sd0, 16'sd131, -16'sd131},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'sd0},
      '{16'sh8000, 16'sd0, 16'sd0, 16'sd2, -16'sd2},
      '{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0},
      '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
      '{16'sd2896, 16'sd0, 16'sd2896, 16'sd100, 16'sd100},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}
    };
    foreach (directed[i]) send_sample(directed[i]);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin acc_v = '{8191, 8191, 8191};    gyr_v = '{32767, 32767}; end
        1: begin acc_v = '{-8192, -8192, -8192}; gyr_v = '{-32768, -32768}; end
        2: begin acc_v = '{4096, -4096, 4096};   gyr_v = '{25600, -25600}; end
        3: begin acc_v = '{-4096, 4096, -4096};  gyr_v = '{-25600, 25600}; end
        4: begin acc_v = '{0, 0, 0};             gyr_v = '{0, 0}; end
        default: begin
          foreach (acc_v[i]) acc_v[i] = $urandom_range(0, 8192) - 4096;
          foreach (gyr_v[i]) gyr_v[i] = $urandom_range(0, 51200) - 25600;
        end
      endcase
      load_offsets(acc_v, gyr_v);
      send_sample('{-raw_t'(sb.acc_off[0]), -raw_t'(sb.acc_off[1]), -raw_t'(sb.acc_off[2]),
                    16'sh7fff, 16'sh8000});
      if (phase == 5) idle_en = 1'b0;
      repeat (230) send_sample(rand_sample());
    end

    smp.valid <= 1'b0;
    idle_en = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    $display("Covered %0d sample sets and %0d results over six offset settings.",
             sb.noted, sb.checked);
    $display("Issued %0d register writes, including ignored indexes.", cfg_writes);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
